### rtl/rpf_pkg.sv
// shared types, register indexes and constants of the region pixel filter
package rpf_pkg;

   // largest image dimension the counters support
   localparam int MAX_DIM_DEFAULT = 4096;

   // field widths
   localparam int CHAN_W   = 8;
   localparam int MODE_W   = 2;
   localparam int SIZE_W   = 13;
   localparam int BOUND_W  = 12;
   localparam int THRESH_W = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;
   localparam int CHAN_SUM_W = 10;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE          = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_LEFT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_TOP    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_RIGHT  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_BOTTOM = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_THRESHOLD = 3'd7;

   // mode codes
   localparam logic [MODE_W-1:0] MODE_INVERT   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_GRAY     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BINARIZE = 2'd2;

   // full-scale channel value
   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

   // luma: (114*b + 587*g + 299*r + 499) / 1000, divide by reciprocal multiply
   localparam int LUMA_SUM_W   = 18;
   localparam int LUMA_RECIP_W = 19;
   localparam int LUMA_PROD_W  = LUMA_SUM_W + LUMA_RECIP_W;
   localparam int LUMA_SHIFT   = 28;
   localparam logic [LUMA_SUM_W-1:0]   LUMA_WB    = 18'd114;
   localparam logic [LUMA_SUM_W-1:0]   LUMA_WG    = 18'd587;
   localparam logic [LUMA_SUM_W-1:0]   LUMA_WR    = 18'd299;
   localparam logic [LUMA_SUM_W-1:0]   LUMA_BIAS  = 18'd499;
   localparam logic [LUMA_RECIP_W-1:0] LUMA_RECIP = 19'd268436;

   // per-pixel operation picked from mode and position
   typedef enum logic [1:0] {
      OP_PASS,
      OP_INVERT,
      OP_GRAY,
      OP_BINARIZE
   } op_type;

   // configuration registers
   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [SIZE_W-1:0]   image_width;
      logic [SIZE_W-1:0]   image_height;
      logic [BOUND_W-1:0]  region_left;
      logic [BOUND_W-1:0]  region_top;
      logic [BOUND_W-1:0]  region_right;
      logic [BOUND_W-1:0]  region_bottom;
      logic [THRESH_W-1:0] bin_threshold;
   } cfg_type;

   // position decision for the pixel being accepted
   typedef struct packed {
      op_type op;
      logic   frame_end;
   } pos_type;

endpackage

### rtl/region_pixel_filter_top.sv
// region pixel filter: config registers, three-stage pixel pipeline, result register
// each pixel passes the stage 1, stage 2 and result registers in order before its result is valid
// throughput: one pixel per cycle; every stage holds when the result side stalls
// the luma divide is a reciprocal multiply in the last stage
// reset: synchronous, clears counters, pipeline valids and configuration
// (mode 0, width 1, height 1, other registers 0)
module region_pixel_filter_top
   import rpf_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CHAN_W-1:0]     req_red,
   input  logic [CHAN_W-1:0]     req_green,
   input  logic [CHAN_W-1:0]     req_blue,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CHAN_W-1:0]     rsp_red,
   output logic [CHAN_W-1:0]     rsp_green,
   output logic [CHAN_W-1:0]     rsp_blue,
   output logic                  rsp_frame_end
);

   cfg_type cfg_ff;
   pos_type pos;

   logic req_xfer, s1_en, s2_en, out_en;

   logic                  s1_v_ff;
   op_type                s1_op_ff;
   logic                  s1_end_ff;
   logic [CHAN_W-1:0]     s1_red_ff, s1_green_ff, s1_blue_ff;

   logic                  s2_v_ff;
   op_type                s2_op_ff;
   logic                  s2_end_ff;
   logic [CHAN_W-1:0]     s2_red_ff, s2_green_ff, s2_blue_ff;
   logic [LUMA_SUM_W-1:0] s2_sum_ff;

   logic                  out_v_ff;
   op_type                out_op_ff;
   logic                  out_end_ff;
   logic [CHAN_W-1:0]     out_red_ff, out_green_ff, out_blue_ff;

   logic [LUMA_SUM_W-1:0]  luma_sum_in;
   logic [CHAN_SUM_W-1:0]  chan_sum;
   logic [CHAN_W-1:0]      s2_red_in, s2_green_in, s2_blue_in, bin_v;
   logic [LUMA_PROD_W-1:0] luma_prod;
   logic [CHAN_W-1:0]      luma_q;
   logic [CHAN_W-1:0]      out_red_in, out_green_in, out_blue_in;

   // stall chain from the result side back to the input
   assign out_en    = !out_v_ff || rsp_ready;
   assign s2_en     = !s2_v_ff || out_en;
   assign s1_en     = !s1_v_ff || s2_en;
   assign req_ready = s1_en;
   assign req_xfer  = req_valid && req_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{mode: MODE_INVERT, image_width: SIZE_W'(1), image_height: SIZE_W'(1),
                     default: '0};
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MODE:          cfg_ff.mode          <= csr_wdata[MODE_W-1:0];
            CSR_IMAGE_WIDTH:   cfg_ff.image_width   <= csr_wdata[SIZE_W-1:0];
            CSR_IMAGE_HEIGHT:  cfg_ff.image_height  <= csr_wdata[SIZE_W-1:0];
            CSR_REGION_LEFT:   cfg_ff.region_left   <= csr_wdata[BOUND_W-1:0];
            CSR_REGION_TOP:    cfg_ff.region_top    <= csr_wdata[BOUND_W-1:0];
            CSR_REGION_RIGHT:  cfg_ff.region_right  <= csr_wdata[BOUND_W-1:0];
            CSR_REGION_BOTTOM: cfg_ff.region_bottom <= csr_wdata[BOUND_W-1:0];
            CSR_BIN_THRESHOLD: cfg_ff.bin_threshold <= csr_wdata[THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   // pixel position and operation
   rpf_position #(
      .MAX_DIM(MAX_DIM)
   ) u_position (
      .clock(clock),
      .reset(reset),
      .step (req_xfer),
      .cfg  (cfg_ff),
      .pos  (pos)
   );

   // stage 1: input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_en) begin
         s1_v_ff <= req_valid;
      end
      if (req_xfer) begin
         s1_op_ff    <= pos.op;
         s1_end_ff   <= pos.frame_end;
         s1_red_ff   <= req_red;
         s1_green_ff <= req_green;
         s1_blue_ff  <= req_blue;
      end
   end

   // weighted luma sum, binarize and invert
   always_comb begin
      luma_sum_in = LUMA_SUM_W'(s1_blue_ff) * LUMA_WB + LUMA_SUM_W'(s1_green_ff) * LUMA_WG
                  + LUMA_SUM_W'(s1_red_ff) * LUMA_WR + LUMA_BIAS;
      chan_sum = CHAN_SUM_W'(s1_red_ff) + CHAN_SUM_W'(s1_green_ff) + CHAN_SUM_W'(s1_blue_ff);
      bin_v = (chan_sum >= cfg_ff.bin_threshold) ? CHAN_MAX : '0;
      case (s1_op_ff)
         OP_INVERT: begin
            s2_red_in   = CHAN_MAX - s1_red_ff;
            s2_green_in = CHAN_MAX - s1_green_ff;
            s2_blue_in  = CHAN_MAX - s1_blue_ff;
         end
         OP_BINARIZE: begin
            s2_red_in   = bin_v;
            s2_green_in = bin_v;
            s2_blue_in  = bin_v;
         end
         default: begin
            s2_red_in   = s1_red_ff;
            s2_green_in = s1_green_ff;
            s2_blue_in  = s1_blue_ff;
         end
      endcase
   end

   // stage 2 register
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s2_en) begin
         s2_v_ff <= s1_v_ff;
      end
      if (s2_en && s1_v_ff) begin
         s2_op_ff    <= s1_op_ff;
         s2_end_ff   <= s1_end_ff;
         s2_red_ff   <= s2_red_in;
         s2_green_ff <= s2_green_in;
         s2_blue_ff  <= s2_blue_in;
         s2_sum_ff   <= luma_sum_in;
      end
   end

   // divide by 1000 through the reciprocal, then pick the luma for gray pixels
   always_comb begin
      luma_prod = LUMA_PROD_W'(s2_sum_ff) * LUMA_PROD_W'(LUMA_RECIP);
      luma_q    = luma_prod[LUMA_SHIFT +: CHAN_W];
      if (s2_op_ff == OP_GRAY) begin
         out_red_in   = luma_q;
         out_green_in = luma_q;
         out_blue_in  = luma_q;
      end else begin
         out_red_in   = s2_red_ff;
         out_green_in = s2_green_ff;
         out_blue_in  = s2_blue_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_en) begin
         out_v_ff <= s2_v_ff;
      end
      if (out_en && s2_v_ff) begin
         out_op_ff    <= s2_op_ff;
         out_end_ff   <= s2_end_ff;
         out_red_ff   <= out_red_in;
         out_green_ff <= out_green_in;
         out_blue_ff  <= out_blue_in;
      end
   end

   assign rsp_valid     = out_v_ff;
   assign rsp_red       = out_red_ff;
   assign rsp_green     = out_green_ff;
   assign rsp_blue      = out_blue_ff;
   assign rsp_frame_end = out_end_ff;

   // a full pipeline with a stalled result takes no new pixel
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && s2_v_ff && out_v_ff && !rsp_ready |-> !req_ready)
      else $error("pixel accepted into a full pipeline");

   // a stalled stage 2 item is kept
   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      s2_v_ff && !out_en |=> s2_v_ff && $stable(s2_sum_ff))
      else $error("stage 2 item lost during stall");

   // gray and binarized pixels have equal channels
   a_equal_chan: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && (out_op_ff == OP_GRAY || out_op_ff == OP_BINARIZE)
      |-> out_red_ff == out_green_ff && out_green_ff == out_blue_ff)
      else $error("gray or binary pixel with unequal channels");

   // binarized pixels are black or white
   a_bin_level: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_op_ff == OP_BINARIZE |-> out_red_ff == '0 || out_red_ff == CHAN_MAX)
      else $error("binarized pixel not black or white");

endmodule

### rtl/rpf_position.sv
// column and row counters with region and frame-end decode
module rpf_position
   import rpf_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  cfg_type cfg,
   output pos_type pos
);

   localparam int CNT_W = $clog2(MAX_DIM);
   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int CMP_W = (DIM_W > SIZE_W) ? DIM_W : SIZE_W;
   localparam logic [CMP_W-1:0] MAX_V = CMP_W'(MAX_DIM);
   localparam logic [CMP_W-1:0] ONE_V = CMP_W'(1);

   logic [CNT_W-1:0] col_ff, col_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic [CMP_W-1:0] width_raw, height_raw, eff_w, eff_h;
   logic [CMP_W-1:0] lf, rt, tp, bt, col_x, row_x;
   logic             last_col, last_row, in_incl, in_excl;

   // bound clamped to dimension minus one
   function automatic logic [CMP_W-1:0] clamp_bound(input logic [CMP_W-1:0] b,
                                                    input logic [CMP_W-1:0] dim);
      clamp_bound = (b >= dim) ? dim - ONE_V : b;
   endfunction

   // effective image size
   always_comb begin
      width_raw  = CMP_W'(cfg.image_width);
      height_raw = CMP_W'(cfg.image_height);
      eff_w = (width_raw == '0) ? ONE_V : ((width_raw > MAX_V) ? MAX_V : width_raw);
      eff_h = (height_raw == '0) ? ONE_V : ((height_raw > MAX_V) ? MAX_V : height_raw);
   end

   // clamped region bounds and position compares
   always_comb begin
      lf = clamp_bound(CMP_W'(cfg.region_left), eff_w);
      rt = clamp_bound(CMP_W'(cfg.region_right), eff_w);
      tp = clamp_bound(CMP_W'(cfg.region_top), eff_h);
      bt = clamp_bound(CMP_W'(cfg.region_bottom), eff_h);
      col_x = CMP_W'(col_ff);
      row_x = CMP_W'(row_ff);
      last_col = col_x >= eff_w - ONE_V;
      last_row = row_x >= eff_h - ONE_V;
      in_incl = (col_x >= lf) && (col_x <= rt) && (row_x >= tp) && (row_x <= bt);
      in_excl = (col_x >= lf) && (col_x < rt) && (row_x >= tp) && (row_x < bt);
   end

   // operation decode
   always_comb begin
      pos.frame_end = last_col && last_row;
      unique case (cfg.mode)
         MODE_INVERT:   pos.op = in_incl ? OP_INVERT : OP_PASS;
         MODE_GRAY:     pos.op = in_excl ? OP_GRAY : OP_PASS;
         MODE_BINARIZE: pos.op = OP_BINARIZE;
         default:       pos.op = OP_PASS;
      endcase
   end

   // next counter values, wrap at the last column and row
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : row_ff + CNT_W'(1);
      end else begin
         col_in = col_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (step) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // frame end leaves both counters at the origin
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      step && pos.frame_end |=> col_ff == '0 && row_ff == '0)
      else $error("counters not cleared after frame end");

   // inside a row the column advances by one
   a_col_step: assert property (@(posedge clock) disable iff (reset)
      step && !last_col |=> col_ff == $past(col_ff) + CNT_W'(1) && row_ff == $past(row_ff))
      else $error("column counter did not advance");

endmodule
